>>> design/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Every property is sampled on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked concurrent assertion with reset disable.
`define B64D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: when trig holds, cons must hold in the same cycle.
`define B64D_ASSERT_IMPL(label, trig, cons, msg) \
  `B64D_ASSERT(label, (trig) |-> (cons), msg)

// Next-cycle form: when trig holds, cons must hold in the next cycle.
`define B64D_ASSERT_NEXT(label, trig, cons, msg) \
  `B64D_ASSERT(label, (trig) |=> (cons), msg)

`endif

>>> design/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants for the base64 stream decoder: the input and
// output transfer payloads and the job record passed from front to back.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Default depth of the job queue between front and back
  localparam int unsigned JobQueueDepth = 4;

  // Most bytes one character can release
  localparam int unsigned MaxBytesPerJob = 3;

  // One character of the encoded text
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_item_t;

  // One result of the decoder
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
  } out_item_t;

  // Work for the back end: bytes[0] goes out first, cnt bytes are live.
  // cnt of zero with eot set is a byteless end marker.
  typedef struct packed {
    logic [MaxBytesPerJob-1:0][7:0] bytes;
    logic [1:0]                     cnt;
    logic                           eot;
  } job_t;

endpackage

>>> design/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Input side: classifies each character, gathers sextets into groups and
// turns each accepted character into a job of zero to three bytes.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  b64d_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output b64d_pkg::job_t    job_o
);
  import b64d_pkg::*;

  // Alphabet anchors
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharDigit0 = 8'h30;
  localparam logic [7:0] CharDigit9 = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharSlash  = 8'h2F;
  // Offsets that move each range to its sextet value
  localparam logic [7:0] LowerOffset = 8'd71;  // 'a' - 26
  localparam logic [7:0] DigitOffset = 8'd4;   // 52 - '0'

  // Sextet value in [5:0], bit 6 set for anything outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    begin
      t = 8'h00;
      r = 7'h40;
      if (c >= CharUpperA && c <= CharUpperZ) begin
        t = c - CharUpperA;
        r = {1'b0, t[5:0]};
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
        t = c - LowerOffset;
        r = {1'b0, t[5:0]};
      end else if (c >= CharDigit0 && c <= CharDigit9) begin
        t = c + DigitOffset;
        r = {1'b0, t[5:0]};
      end else if (c == CharPlus) begin
        r = 7'd62;
      end else if (c == CharSlash) begin
        r = 7'd63;
      end
      sextet_of = r;
    end
  endfunction

  // Bytes of a partial group: one fewer than its sextet count
  function automatic job_t flush_job(input logic [1:0] gc, input logic [17:0] st,
                                     input logic eot);
    job_t j;
    begin
      j          = '0;
      j.eot      = eot;
      j.bytes[1] = st[9:2];
      if (gc == 2'd3) begin
        j.cnt      = 2'd2;
        j.bytes[0] = st[17:10];
      end else if (gc == 2'd2) begin
        j.cnt      = 2'd1;
        j.bytes[0] = st[11:4];
      end
      flush_job = j;
    end
  endfunction

  logic [1:0]  gc_q, gc_d, gc_step;
  logic [17:0] st_q, st_d, st_step;
  logic        stop_q, stop_d, stop_step;
  logic [6:0]  sx;
  logic        accept;
  job_t        job;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Group state update and job build for one character
  always_comb begin
    sx        = sextet_of(in_data_i.char_in);
    gc_step   = gc_q;
    st_step   = st_q;
    stop_step = stop_q;
    job       = '0;
    job.eot   = in_data_i.end_of_text;
    if (!stop_q) begin
      if (!sx[6]) begin
        if (gc_q == 2'd3) begin
          // group complete: three bytes out
          job.cnt      = 2'd3;
          job.bytes[0] = st_q[17:10];
          job.bytes[1] = {st_q[9:2]};
          job.bytes[2] = {st_q[1:0], sx[5:0]};
          gc_step      = 2'd0;
          st_step      = '0;
        end else begin
          st_step = {st_q[11:0], sx[5:0]};
          gc_step = gc_q + 2'd1;
        end
      end else begin
        // stop character: flush partial group
        job       = flush_job(gc_q, st_q, in_data_i.end_of_text);
        gc_step   = 2'd0;
        st_step   = '0;
        stop_step = 1'b1;
      end
    end
    gc_d   = gc_step;
    st_d   = st_step;
    stop_d = stop_step;
    if (in_data_i.end_of_text) begin
      if (job.cnt == 2'd0 && !stop_step) begin
        job = flush_job(gc_step, st_step, 1'b1);
      end
      gc_d   = 2'd0;
      st_d   = '0;
      stop_d = 1'b0;
    end
  end

  // Only characters that release something go into the queue
  assign push_o = accept && (job.cnt != 2'd0 || job.eot);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q   <= 2'd0;
      st_q   <= '0;
      stop_q <= 1'b0;
    end else if (accept) begin
      gc_q   <= gc_d;
      st_q   <= st_d;
      stop_q <= stop_d;
    end
  end

endmodule

>>> design/b64d_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_fifo
// Short job queue between front and back; head is visible while not empty.
// ----------------------------------------------------------------------------
module b64d_fifo #(
  parameter int unsigned Depth = b64d_pkg::JobQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output b64d_pkg::job_t data_o,
  output logic           empty_o
);
  import b64d_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  job_t             mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> design/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Output side: walks the head job one byte per transfer into an output
// register, marks the last result of a text and retires the job.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b64d_pkg::job_t     head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output b64d_pkg::out_item_t out_data_o
);
  import b64d_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, res;
  logic       load, last, has_bytes;

  assign load      = head_valid_i && (!out_valid_q || !out_stall_i);
  assign has_bytes = (head_i.cnt != 2'd0);
  assign last      = !has_bytes || (idx_q == head_i.cnt - 2'd1);
  assign pop_o     = load && last;

  // Next result from the head job
  always_comb begin
    res.data_byte   = has_bytes ? head_i.bytes[idx_q] : 8'h00;
    res.byte_valid  = has_bytes;
    res.message_end = last && head_i.eot;
    idx_d           = idx_q;
    out_valid_d     = out_valid_q;
    if (load) begin
      idx_d       = last ? 2'd0 : idx_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/base64_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: one character in, decoded bytes out.
// ----------------------------------------------------------------------------
// Takes one character per cycle. Each character releases zero to three
// results (a full group of four gives three bytes; a stop or end of text
// flushes a partial group; an end of text with nothing pending gives one
// byteless marker). Results leave one per cycle, when the receiver does not
// stall, from an output register; each passes the job queue and then that
// register. Input stalls only when the job queue (QueueDepth entries) is full,
// which happens when the output side has been stalled; the output rate of one
// result per cycle is what sets the sustained character rate.
module base64_stream_decoder_core #(
  parameter int unsigned QueueDepth = b64d_pkg::JobQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b64d_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b64d_pkg::out_item_t out_data_o
);
  import b64d_pkg::*;

  logic push, full, pop, empty;
  job_t job_in, job_head;

  // Character classification and grouping
  b64d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  // Job queue
  b64d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_head),
    .empty_o (empty)
  );

  // Byte serializer and output register
  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (job_head),
    .head_valid_i (!empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

>>> design/b64d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks for the base64 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input b64d_pkg::out_item_t out_data_o
);
  import b64d_pkg::*;

  logic out_held;
  logic out_marker;

  // Offered result waiting on the receiver, and byteless result on offer
  assign out_held   = out_valid_o && out_stall_i;
  assign out_marker = out_valid_o && !out_data_o.byte_valid;

  // A stalled result stays offered
  `B64D_ASSERT_NEXT(a_out_hold, out_held, out_valid_o, "out_valid_o dropped while stalled")

  // A stalled result keeps its payload
  `B64D_ASSERT_NEXT(a_out_stable, out_held, $stable(out_data_o), "out_data_o moved while stalled")

  // A byteless result only ever closes a message
  `B64D_ASSERT_IMPL(a_marker_end, out_marker, out_data_o.message_end, "marker without message_end")

  // A byteless result carries a zero byte
  `B64D_ASSERT_IMPL(a_marker_zero, out_marker, out_data_o.data_byte == 8'h00, "marker with nonzero byte")

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_stream_decoder_core: feeds encoded text one
// character per transfer, predicts the decoded bytes and end marks, and
// checks every output transfer in order under random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import b64d_pkg::*;

  // Row count codes for the stimulus table
  localparam logic signed [3:0] Predicted = -4'sd1;
  localparam logic signed [3:0] EndMarker = -4'sd2;

  localparam int RandomChars = 330;
  localparam int IdleLimit   = 5000;
  localparam int DrainCycles = 8;

  // One character to send; n gives the results typed in by hand, or a code
  typedef struct packed {
    logic [7:0]        ch;
    logic              eot;
    logic signed [3:0] n;
    logic [23:0]       bytes;
  } char_row_t;

  // Directed text: plain group, all-ones group, markers, padding, stop chars
  localparam char_row_t DirectedTbl [25] = '{
    '{"T", 1'b0, Predicted, 24'h0},
    '{"W", 1'b0, Predicted, 24'h0},
    '{"F", 1'b0, Predicted, 24'h0},
    '{"u", 1'b0, 4'sd3, 24'h4d616e},
    '{"/", 1'b0, Predicted, 24'h0},
    '{"/", 1'b0, Predicted, 24'h0},
    '{"/", 1'b0, Predicted, 24'h0},
    '{"/", 1'b1, 4'sd3, 24'hffffff},
    '{8'h00, 1'b1, EndMarker, 24'h0},
    '{"A", 1'b1, EndMarker, 24'h0},
    '{"A", 1'b0, Predicted, 24'h0},
    '{"A", 1'b1, 4'sd1, 24'h000000},
    '{"T", 1'b0, Predicted, 24'h0},
    '{"W", 1'b0, Predicted, 24'h0},
    '{"E", 1'b0, Predicted, 24'h0},
    '{"=", 1'b1, 4'sd2, 24'h4d6100},
    '{"Q", 1'b0, Predicted, 24'h0},
    '{"Q", 1'b0, Predicted, 24'h0},
    '{8'h80, 1'b0, 4'sd1, 24'h410000},
    '{8'hff, 1'b0, 4'sd0, 24'h0},
    '{"z", 1'b1, EndMarker, 24'h0},
    '{"+", 1'b0, Predicted, 24'h0},
    '{"z", 1'b0, Predicted, 24'h0},
    '{"0", 1'b0, Predicted, 24'h0},
    '{"9", 1'b1, Predicted, 24'h0}
  };

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  base64_stream_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  char_row_t text_q [$];
  out_item_t decoded_q [$];
  out_item_t step_res_q [$];

  // Predictor state
  logic [1:0]  grp_cnt;
  logic [17:0] grp_bits;
  logic        dec_stopped;

  int errors;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sextet value of a character, 64 when outside the alphabet
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
    if (c == "+") return 7'd62;
    if (c == "/") return 7'd63;
    return 7'd64;
  endfunction

  function automatic logic [7:0] alphabet_char(input int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  // Partial group out: one byte fewer than the sextets held
  task automatic flush_group();
    if (grp_cnt == 2'd2) begin
      step_res_q.push_back('{grp_bits[11:4], 1'b1, 1'b0});
    end else if (grp_cnt == 2'd3) begin
      step_res_q.push_back('{grp_bits[17:10], 1'b1, 1'b0});
      step_res_q.push_back('{grp_bits[9:2], 1'b1, 1'b0});
    end
    grp_cnt  = '0;
    grp_bits = '0;
  endtask

  // Decode one character into step_res_q
  task automatic decode_char(input logic [7:0] c, input logic eot);
    logic [6:0]  v;
    logic [23:0] word;
    step_res_q.delete();
    if (!dec_stopped) begin
      v = sextet_value(c);
      if (v < 7'd64) begin
        if (grp_cnt == 2'd3) begin
          word = {grp_bits, v[5:0]};
          step_res_q.push_back('{word[23:16], 1'b1, 1'b0});
          step_res_q.push_back('{word[15:8], 1'b1, 1'b0});
          step_res_q.push_back('{word[7:0], 1'b1, 1'b0});
          grp_cnt  = '0;
          grp_bits = '0;
        end else begin
          grp_bits = {grp_bits[11:0], v[5:0]};
          grp_cnt  = grp_cnt + 2'd1;
        end
      end else begin
        flush_group();
        dec_stopped = 1'b1;
      end
    end
    if (eot) begin
      if (step_res_q.size() == 0 && !dec_stopped) flush_group();
      if (step_res_q.size() == 0) step_res_q.push_back('{8'h00, 1'b0, 1'b0});
      step_res_q[step_res_q.size()-1].message_end = 1'b1;
      grp_cnt     = '0;
      grp_bits    = '0;
      dec_stopped = 1'b0;
    end
  endtask

  // Queue the results of an accepted character, typed or predicted
  task automatic accept_char(input char_row_t r);
    decode_char(r.ch, r.eot);
    if (r.n == Predicted) begin
      foreach (step_res_q[k]) decoded_q.push_back(step_res_q[k]);
    end else if (r.n == EndMarker) begin
      decoded_q.push_back('{8'h00, 1'b0, 1'b1});
    end else begin
      for (int k = 0; k < int'(r.n); k++) begin
        decoded_q.push_back('{r.bytes[23-8*k -: 8], 1'b1, r.eot && (k == int'(r.n) - 1)});
      end
    end
  endtask

  // Random texts: mostly well-formed, some with stop chars, some pure noise
  task automatic build_random_text();
    logic [7:0] text [$];
    logic [7:0] c;
    int total;
    int kind;
    int len;
    int pos;
    total = 0;
    while (total < RandomChars) begin
      text.delete();
      kind = $urandom_range(0, 9);
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        if (kind >= 8) text.push_back(8'($urandom_range(0, 255)));
        else text.push_back(alphabet_char($urandom_range(0, 63)));
      end
      if (kind >= 6 && kind <= 7) begin
        // stop char somewhere in the text
        do c = 8'($urandom_range(0, 255)); while (sextet_value(c) != 7'd64);
        if ($urandom_range(0, 1) == 1) c = "=";
        pos = $urandom_range(0, text.size());
        text.insert(pos, c);
      end else if (kind <= 5 && (len % 4) >= 2 && $urandom_range(0, 1) == 1) begin
        while ((text.size() % 4) != 0) text.push_back("=");
      end
      // trailing junk at the end of some texts
      if (kind <= 7 && $urandom_range(0, 3) == 0) begin
        for (int k = $urandom_range(1, 3); k > 0; k--) text.push_back(8'($urandom_range(0, 255)));
      end
      foreach (text[k]) begin
        text_q.push_back('{text[k], k == text.size() - 1, Predicted, 24'h0});
      end
      total += text.size();
    end
  endtask

  // Sender: walks the text queue in bursts with random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        accept_char(text_q.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (text_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= '{text_q[0].ch, text_q[0].eot};
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall mode changes every segment
  int stall_mode;
  int seg_left;
  int hold_left;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (seg_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        seg_left   = $urandom_range(20, 80);
      end
      seg_left--;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: begin
          // long stall stretches with short releases
          if (hold_left > 0) begin
            hold_left--;
            out_stall_i <= 1'b1;
          end else begin
            hold_left = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 20) : 0;
            out_stall_i <= 1'b0;
          end
        end
      endcase
    end
  end

  // Output check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected output transfer, expected none, got %h/%b/%b",
                   $time, out_data_o.data_byte, out_data_o.byte_valid,
                   out_data_o.message_end);
          errors++;
        end else begin
          if (out_data_o.data_byte !== decoded_q[0].data_byte) begin
            $display("%0t: data_byte expected %h got %h",
                     $time, decoded_q[0].data_byte, out_data_o.data_byte);
            errors++;
          end
          if (out_data_o.byte_valid !== decoded_q[0].byte_valid) begin
            $display("%0t: byte_valid expected %b got %b",
                     $time, decoded_q[0].byte_valid, out_data_o.byte_valid);
            errors++;
          end
          if (out_data_o.message_end !== decoded_q[0].message_end) begin
            $display("%0t: message_end expected %b got %b",
                     $time, decoded_q[0].message_end, out_data_o.message_end);
            errors++;
          end
          void'(decoded_q.pop_front());
        end
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("tb NOT OK");
          $finish;
        end
      end
    end
  end

  // Reset, stimulus build and end of run
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    grp_cnt     = '0;
    grp_bits    = '0;
    dec_stopped = 1'b0;
    errors      = 0;
    idle_cycles = 0;
    burst_left  = 1;
    gap_left    = 0;
    stall_mode  = 0;
    seg_left    = 30;
    hold_left   = 0;
    foreach (DirectedTbl[k]) text_q.push_back(DirectedTbl[k]);
    build_random_text();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (text_q.size() > 0 || decoded_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
